### rtl/lpc_pkg.sv
// shared types, constants and weight table for the line position centroid block
package lpc_pkg;

    localparam int SENSOR_COUNT = 8;
    localparam int POS_BITS     = 14;
    localparam int FRAC_BITS    = 10;
    localparam int QUOT_BITS    = 13;
    localparam int CNT_W        = 4;
    localparam int SEL_W        = 3;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_ACC  = 5'b00010,
        ST_PREP = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } lpc_state_t;

    typedef struct packed {
        logic             load;
        logic             acc;
        logic [SEL_W-1:0] acc_idx;
        logic             div_init;
        logic             div_step;
        logic             finish;
    } lpc_cmd_t;

    typedef struct packed {
        logic out_full;
    } lpc_status_t;

    function automatic logic signed [3:0] lpc_weight(input logic [SEL_W-1:0] idx);
        logic signed [3:0] w;
        case (idx)
            3'd0:    w = -4'sd7;
            3'd1:    w = -4'sd6;
            3'd2:    w = -4'sd4;
            3'd3:    w = -4'sd1;
            3'd4:    w = 4'sd1;
            3'd5:    w = 4'sd4;
            3'd6:    w = 4'sd6;
            3'd7:    w = 4'sd7;
            default: w = 4'sd0;
        endcase
        return w;
    endfunction

endpackage

### rtl/lpc_ctrl.sv
// sequencer: accept, accumulate over sensors, divide, hand off result
module lpc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  lpc_pkg::lpc_status_t sts,
    output lpc_pkg::lpc_cmd_t   cmd
);
    import lpc_pkg::*;

    lpc_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.acc_idx  = cnt_reg[SEL_W-1:0];
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                cmd.acc = 1'b1;
                if (cnt_reg == CNT_W'(SENSOR_COUNT - 1)) begin
                    state_next = ST_PREP;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_PREP: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(QUOT_BITS - 1)) begin
                    state_next = ST_OUT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_OUT: begin
                // wait for the output slot to free up
                if (!sts.out_full) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/lpc_datapath.sv
// sample registers, weighted and plain accumulators, serial divider, output register
module lpc_datapath #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic                                   cfg_wr_data,
    input  logic [lpc_pkg::SENSOR_COUNT*SAMPLE_BITS-1:0] s_tdata,
    input  lpc_pkg::lpc_cmd_t                      cmd,
    output lpc_pkg::lpc_status_t                   sts,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [15:0]                            m_tdata,
    output logic                                   m_tuser
);
    import lpc_pkg::*;

    localparam int SW    = SAMPLE_BITS + 1;   // inverted sample can reach 2^bits
    localparam int WS_W  = SAMPLE_BITS + 7;   // signed weighted sum
    localparam int MAG_W = SAMPLE_BITS + 6;
    localparam int REM_W = SAMPLE_BITS + 4;   // plain sum width
    localparam int DROP  = QUOT_BITS - FRAC_BITS;

    logic                      invert_reg;
    logic [SW-1:0]             samp_reg [SENSOR_COUNT];
    logic signed [WS_W-1:0]    ws_reg;
    logic [REM_W-1:0]          plain_reg;
    logic                      neg_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [QUOT_BITS-1:0]      dvd_reg;
    logic [QUOT_BITS-1:0]      quo_reg;
    logic signed [POS_BITS-1:0] last_reg;
    logic                      m_valid_reg;
    logic [POS_BITS-1:0]       pos_out_reg;
    logic                      held_reg;

    logic signed [WS_W-1:0]    samp_s, w_s, prod;
    logic [WS_W-1:0]           ws_abs;
    logic [MAG_W-1:0]          mag;
    logic [REM_W:0]            trial;
    logic                      fits;
    logic [POS_BITS-1:0]       quo_ext, pos_new;
    logic [SW-1:0]             full_scale;

    assign full_scale = {1'b1, {SAMPLE_BITS{1'b0}}};
    assign samp_s  = WS_W'($signed({1'b0, samp_reg[0]}));
    assign w_s     = WS_W'(lpc_weight(cmd.acc_idx));
    assign prod    = w_s * samp_s;
    assign ws_abs  = ws_reg[WS_W-1] ? WS_W'(-ws_reg) : WS_W'(ws_reg);
    assign mag     = ws_abs[MAG_W-1:0];
    assign trial   = {rem_reg, dvd_reg[QUOT_BITS-1]};
    assign fits    = trial >= {1'b0, plain_reg};
    assign quo_ext = {1'b0, quo_reg};
    assign pos_new = neg_reg ? POS_BITS'(-quo_ext) : quo_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            invert_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            invert_reg <= cfg_wr_data;
        end
    end

    // samples shift toward slot 0 while accumulating
    always_ff @(posedge aclk) begin
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (cmd.load) begin
                if (invert_reg) begin
                    samp_reg[i] <= full_scale - {1'b0, s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS]};
                end else begin
                    samp_reg[i] <= {1'b0, s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS]};
                end
            end else if (cmd.acc) begin
                if (i == SENSOR_COUNT - 1) begin
                    samp_reg[i] <= '0;
                end else begin
                    samp_reg[i] <= samp_reg[i+1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ws_reg    <= '0;
            plain_reg <= '0;
        end else if (cmd.acc) begin
            ws_reg    <= ws_reg + prod;
            plain_reg <= plain_reg + REM_W'(samp_reg[0]);
        end
    end

    // restoring division of |ws| * 2^FRAC_BITS by the plain sum; the quotient stays below
    // 2^QUOT_BITS, so the remainder starts from the dividend's upper bits
    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            neg_reg <= ws_reg[WS_W-1];
            rem_reg <= REM_W'(mag[MAG_W-1:DROP]);
            dvd_reg <= {mag[DROP-1:0], {FRAC_BITS{1'b0}}};
            quo_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= fits ? REM_W'(trial - {1'b0, plain_reg}) : trial[REM_W-1:0];
            dvd_reg <= {dvd_reg[QUOT_BITS-2:0], 1'b0};
            quo_reg <= {quo_reg[QUOT_BITS-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg <= '0;
        end else if (cmd.finish && plain_reg != '0) begin
            last_reg <= $signed(pos_new);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            if (plain_reg == '0) begin
                pos_out_reg <= last_reg;
                held_reg    <= 1'b1;
            end else begin
                pos_out_reg <= pos_new;
                held_reg    <= 1'b0;
            end
        end
    end

    assign sts.out_full = m_valid_reg && !m_tready;
    assign m_tvalid     = m_valid_reg;
    assign m_tdata      = {{(16 - POS_BITS){1'b0}}, pos_out_reg};
    assign m_tuser      = held_reg;

endmodule

### rtl/line_position_centroid.sv
// top level: weighted centroid line position over eight reflectance sensors
// a request is accepted and loaded, the eight sensors are accumulated, the divider is set
// up, the restoring divider steps once per quotient bit and the result is loaded for output
// the accumulator adds one sensor a cycle and the divider finds one quotient bit a cycle; a
// new request is taken only after the result is loaded, which waits until the old one is taken
// reset: synchronous active-low aresetn clears the sequencer, output valid, the
// inversion mode and the stored last position
module line_position_centroid #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic                                   cfg_wr_data,   // invert_samples
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // sample_0 .. sample_7, SAMPLE_BITS each, sample_0 lowest
    input  logic [8*SAMPLE_BITS-1:0]               s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [15:0]                            m_tdata,       // position[13:0], zero pad
    output logic                                   m_tuser        // held
);
    import lpc_pkg::*;

    lpc_cmd_t    cmd;
    lpc_status_t sts;

    lpc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lpc_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // a result is only loaded into a free output slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !(m_tvalid && !m_tready))
        else $error("result loaded over a waiting result");

    // at most one datapath command per cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.acc, cmd.div_init, cmd.div_step, cmd.finish}))
        else $error("overlapping datapath commands");

    // no new request is taken while an item is in work
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !(cmd.acc || cmd.div_init || cmd.div_step || cmd.finish))
        else $error("request accepted during computation");

    // a finish hands the item back to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> s_tready && m_tvalid)
        else $error("finish did not return to idle with a valid result");

endmodule
